>>> rtl/core/sfd_pkg.sv
// Shared types, constants and helpers for the serial frame deframer.
`default_nettype none

package sfd_pkg;

   localparam int FRAME_LIMIT   = 255;
   localparam int PAYLOAD_KEEP  = 14;
   localparam int PAYLOAD_START = 5;
   localparam int STORE_AW      = $clog2(PAYLOAD_KEEP);
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [7:0] FRAME_TAIL  = 8'h7D;
   localparam logic [7:0] CMD_JOINTS  = 8'h06;
   localparam logic [7:0] CMD_VERSION = 8'h09;
   localparam logic [7:0] CMD_UPGRADE = 8'h0A;
   localparam logic [7:0] TYPE_JOINTS = 8'h01;
   localparam logic [7:0] TYPE_SERVO  = 8'h02;

   localparam logic [2:0] JOINT_LAST_IDX = 3'd6;
   localparam logic [2:0] SERVO_LAST_IDX = 3'd4;

   typedef enum logic [2:0] {
      KIND_BAD     = 3'd0,
      KIND_JOINTS  = 3'd1,
      KIND_SERVO   = 3'd2,
      KIND_VERSION = 3'd3,
      KIND_UPGRADE = 3'd4,
      KIND_OTHER   = 3'd5
   } kind_type;

   typedef struct packed {
      logic     valid;
      kind_type kind;
   } frame_event_type;

   typedef struct packed {
      logic                en;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } store_wr_type;

   typedef struct packed {
      logic [STORE_AW-1:0] addr;
      logic                byte_only;
   } rd_sel_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  index;
      logic [15:0] value;
      logic        last;
   } result_type;

   function automatic logic [2:0] last_index(kind_type kind);
      logic [2:0] idx;
      idx = 3'd0;
      if (kind == KIND_JOINTS) begin
         idx = JOINT_LAST_IDX;
      end else if (kind == KIND_SERVO) begin
         idx = SERVO_LAST_IDX;
      end
      return idx;
   endfunction

   // Store address of the low byte of each result word.
   function automatic rd_sel_type item_sel(kind_type kind, logic [2:0] k);
      rd_sel_type s;
      s.addr      = '0;
      s.byte_only = 1'b0;
      if (kind == KIND_JOINTS) begin
         s.addr = STORE_AW'({k, 1'b0});
      end else begin
         case (k)
            3'd0: begin
               s.byte_only = 1'b1;
            end
            3'd1: begin
               s.addr = STORE_AW'(1);
            end
            3'd2: begin
               s.addr = STORE_AW'(3);
            end
            3'd3: begin
               s.addr      = STORE_AW'(5);
               s.byte_only = 1'b1;
            end
            3'd4: begin
               s.addr = STORE_AW'(6);
            end
            default: begin
               s.addr = '0;
            end
         endcase
      end
      return s;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfd_store.sv
// Payload byte store: one write port, two registered read ports (byte and byte + 1).
`default_nettype none

module sfd_store (
   input  wire logic                           clock,
   input  wire sfd_pkg::store_wr_type          wr,
   input  wire logic [sfd_pkg::STORE_AW-1:0]   rd_addr,
   output logic [7:0]                          rd_lo,
   output logic [7:0]                          rd_hi
);

   logic [7:0] mem_ff [sfd_pkg::PAYLOAD_KEEP];
   logic [sfd_pkg::STORE_AW-1:0] rd_addr_hi;

   assign rd_addr_hi = rd_addr + sfd_pkg::STORE_AW'(1);

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_lo <= mem_ff[rd_addr];
      rd_hi <= mem_ff[rd_addr_hi];
   end

endmodule

`default_nettype wire

>>> rtl/core/sfd_parser.sv
// Byte-by-byte frame parser: header, length, checksum, tail and classification.
`default_nettype none

module sfd_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     byte_valid,
   output logic                          byte_ready,
   input  wire logic [7:0]               rx_byte,
   input  wire logic                     cfg_valid,
   input  wire logic [7:0]               cfg_data,
   input  wire logic                     drain_busy,
   output sfd_pkg::frame_event_type      evt,
   output sfd_pkg::store_wr_type         store_wr
);

   logic [7:0] count_ff, count_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] type_ff, type_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] check_ff, check_in;
   logic       hdr2_ff, hdr2_in;
   logic [7:0] servo_cmd_ff;

   logic       accept;
   logic [8:0] pos9;
   logic [8:0] len9;
   logic       frame_ok;

   // While a run is being read out of the store, hold off bytes that could write it
   // or finish another frame.
   assign byte_ready = !(drain_busy && (count_ff >= 8'd4));
   assign accept     = byte_valid && byte_ready;
   assign pos9       = {1'b0, count_ff};

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      cmd_in   = cmd_ff;
      sum_in   = sum_ff;
      check_in = check_ff;
      hdr2_in  = hdr2_ff;
      len9     = {1'b0, len_ff};
      frame_ok = 1'b0;
      evt      = '0;
      evt.kind = sfd_pkg::KIND_BAD;
      store_wr = '0;
      if (accept) begin
         if (count_ff >= 8'(sfd_pkg::FRAME_LIMIT)) begin
            count_in = '0;
         end else if (!(count_ff == 8'd0 && rx_byte != sfd_pkg::SYNC_FIRST)) begin
            if (count_ff == 8'd0) begin
               sum_in  = '0;
               hdr2_in = 1'b0;
            end
            if (count_ff == 8'd1) begin
               hdr2_in = (rx_byte == sfd_pkg::SYNC_SECOND);
            end
            if (count_ff == 8'd2) begin
               len_in = rx_byte;
               len9   = {1'b0, rx_byte};
            end
            if (count_ff == 8'd3) begin
               type_in = rx_byte;
            end
            if (count_ff == 8'd4) begin
               cmd_in = rx_byte;
            end
            if (pos9 >= 9'd3 && pos9 < len9 + 9'd3) begin
               sum_in = sum_ff + rx_byte;
            end
            if (pos9 >= 9'd3 && pos9 == len9 + 9'd3) begin
               check_in = rx_byte;
            end
            if (pos9 >= 9'(sfd_pkg::PAYLOAD_START)
                && pos9 < 9'(sfd_pkg::PAYLOAD_START + sfd_pkg::PAYLOAD_KEEP)) begin
               store_wr.en   = 1'b1;
               store_wr.addr = sfd_pkg::STORE_AW'(count_ff - 8'(sfd_pkg::PAYLOAD_START));
               store_wr.data = rx_byte;
            end
            count_in = count_ff + 8'd1;
            if (pos9 >= 9'd3 && pos9 + 9'd1 >= len9 + 9'd5) begin
               count_in  = '0;
               evt.valid = 1'b1;
               frame_ok  = hdr2_in && (rx_byte == sfd_pkg::FRAME_TAIL) && (sum_in == check_in);
               if (!frame_ok) begin
                  evt.kind = sfd_pkg::KIND_BAD;
               end else if (cmd_in == sfd_pkg::CMD_UPGRADE) begin
                  evt.kind = sfd_pkg::KIND_UPGRADE;
               end else if (cmd_in == sfd_pkg::CMD_VERSION) begin
                  evt.kind = sfd_pkg::KIND_VERSION;
               end else if (cmd_in == sfd_pkg::CMD_JOINTS) begin
                  evt.kind = (type_in == sfd_pkg::TYPE_JOINTS) ? sfd_pkg::KIND_JOINTS
                                                                : sfd_pkg::KIND_OTHER;
               end else if (cmd_in == servo_cmd_ff && type_in == sfd_pkg::TYPE_SERVO) begin
                  evt.kind = sfd_pkg::KIND_SERVO;
               end else begin
                  evt.kind = sfd_pkg::KIND_OTHER;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         len_ff       <= '0;
         type_ff      <= '0;
         cmd_ff       <= '0;
         sum_ff       <= '0;
         check_ff     <= '0;
         hdr2_ff      <= 1'b0;
         servo_cmd_ff <= '0;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         cmd_ff   <= cmd_in;
         sum_ff   <= sum_in;
         check_ff <= check_in;
         hdr2_ff  <= hdr2_in;
         if (cfg_valid) begin
            servo_cmd_ff <= cfg_data;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sfd_drain.sv
// Result sequencer: reads each run out of the store and queues the result items.
`default_nettype none

module sfd_drain (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sfd_pkg::frame_event_type       evt,
   output logic                                busy,
   output logic [sfd_pkg::STORE_AW-1:0]        rd_addr,
   input  wire logic [7:0]                     rd_lo,
   input  wire logic [7:0]                     rd_hi,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output sfd_pkg::result_type                 out_item
);

   logic                  busy_ff, busy_in;
   sfd_pkg::kind_type     kind_ff, kind_in;
   logic [2:0]            k_ff, k_in;

   // read stage: store data arrives in the cycle after the address
   logic                  s1_valid_ff;
   sfd_pkg::kind_type     s1_kind_ff;
   logic [2:0]            s1_idx_ff;
   logic                  s1_last_ff;
   logic                  s1_byte_only_ff;

   sfd_pkg::result_type   fifo_ff [sfd_pkg::FIFO_DEPTH];
   logic [sfd_pkg::FIFO_AW-1:0] wp_ff, rp_ff;
   logic [sfd_pkg::FIFO_AW:0]   cnt_ff, cnt_in;

   sfd_pkg::rd_sel_type   sel;
   sfd_pkg::result_type   s1_item;
   logic                  room;
   logic                  issue;
   logic                  is_last;
   logic                  push;
   logic                  pop;

   assign sel     = sfd_pkg::item_sel(kind_ff, k_ff);
   assign rd_addr = sel.addr;
   assign room    = (cnt_ff + (sfd_pkg::FIFO_AW + 1)'(s1_valid_ff))
                    < (sfd_pkg::FIFO_AW + 1)'(sfd_pkg::FIFO_DEPTH);
   assign issue   = busy_ff && room;
   assign is_last = (k_ff == sfd_pkg::last_index(kind_ff));
   assign busy    = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      k_in    = k_ff;
      if (issue) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            k_in = k_ff + 3'd1;
         end
      end
      if (evt.valid) begin
         busy_in = 1'b1;
         kind_in = evt.kind;
         k_in    = '0;
      end
   end

   always_comb begin
      s1_item.kind  = s1_kind_ff;
      s1_item.index = s1_idx_ff;
      s1_item.last  = s1_last_ff;
      if (s1_kind_ff == sfd_pkg::KIND_JOINTS || s1_kind_ff == sfd_pkg::KIND_SERVO) begin
         s1_item.value = {(s1_byte_only_ff ? 8'h00 : rd_hi), rd_lo};
      end else begin
         s1_item.value = '0;
      end
   end

   assign push      = s1_valid_ff;
   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_item  = fifo_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (sfd_pkg::FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (sfd_pkg::FIFO_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         kind_ff     <= sfd_pkg::KIND_BAD;
         k_ff        <= '0;
         s1_valid_ff <= 1'b0;
         wp_ff       <= '0;
         rp_ff       <= '0;
         cnt_ff      <= '0;
      end else begin
         busy_ff     <= busy_in;
         kind_ff     <= kind_in;
         k_ff        <= k_in;
         s1_valid_ff <= issue;
         cnt_ff      <= cnt_in;
         if (push) begin
            wp_ff <= wp_ff + sfd_pkg::FIFO_AW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + sfd_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff      <= kind_ff;
         s1_idx_ff       <= k_ff;
         s1_last_ff      <= is_last;
         s1_byte_only_ff <= sel.byte_only;
      end
      if (push) begin
         fifo_ff[wp_ff] <= s1_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/serial_frame_deframer_checksum.sv
// Top level of the serial frame deframer with checksum.
//
// req_*: one received byte per item. Frames are 0x55 0xAA L type cmd payload sum 0x7D;
// bytes outside a frame are dropped and a frame longer than 255 bytes is discarded.
// rsp_*: result items. A completed frame gives a run of 1, 5 (servo status) or 7
// (joints) items; tlast marks the final item of each run.
// csr_*: write of the servo-status command byte; csr_ready is always high.
// Throughput: one byte per cycle while req_tready is high. The frame's last byte is
// classified in the cycle it is taken. The run's items pass the sequencer, the store
// read stage and the queue, one per cycle while the queue has room (one read each).
// While a run is still being read out of the payload store, req_tready drops for
// bytes from the fifth of a frame on, so a frame can follow closely but cannot
// overwrite the store early. An 8-entry output queue parts the result side from the
// parser, so bytes keep flowing while rsp_tready is low until the queue fills.
// Reset (synchronous) empties the queue, clears the parser and the register to 0.
`default_nettype none

module serial_frame_deframer_checksum (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [2:0] item_index, [18:3] item_value, zero pad
   output logic [2:0]       rsp_tuser,   // [2:0] frame_kind
   output logic             rsp_tlast,   // run_last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // servo_status_command
);

   sfd_pkg::frame_event_type     evt;
   sfd_pkg::store_wr_type        store_wr;
   sfd_pkg::result_type          out_item;
   logic                         drain_busy;
   logic [sfd_pkg::STORE_AW-1:0] rd_addr;
   logic [7:0]                   rd_lo;
   logic [7:0]                   rd_hi;

   assign csr_ready = 1'b1;

   sfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid),
      .byte_ready (req_tready),
      .rx_byte    (req_tdata),
      .cfg_valid  (csr_valid),
      .cfg_data   (csr_data),
      .drain_busy (drain_busy),
      .evt        (evt),
      .store_wr   (store_wr)
   );

   sfd_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (rd_addr),
      .rd_lo   (rd_lo),
      .rd_hi   (rd_hi)
   );

   sfd_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .evt       (evt),
      .busy      (drain_busy),
      .rd_addr   (rd_addr),
      .rd_lo     (rd_lo),
      .rd_hi     (rd_hi),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {5'b0, out_item.value, out_item.index};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

>>> rtl/core/sfd_checker.sv
// Port-level checks for the deframer, bound to the top level.
`default_nettype none

module sfd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast,
   input wire logic        csr_ready
);

   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item withdrawn while stalled");

   // reset empties the output queue
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result item offered right after reset");

   // kind-only results are single, zero-valued items
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sfd_pkg::KIND_BAD || rsp_tuser == sfd_pkg::KIND_VERSION
                     || rsp_tuser == sfd_pkg::KIND_UPGRADE
                     || rsp_tuser == sfd_pkg::KIND_OTHER)
      |-> rsp_tlast && rsp_tdata[2:0] == 3'd0 && rsp_tdata[18:3] == 16'd0)
      else $error("kind-only result malformed");

   // runs of words end exactly at their final index
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sfd_pkg::KIND_JOINTS || rsp_tuser == sfd_pkg::KIND_SERVO)
      |-> rsp_tlast == ((rsp_tuser == sfd_pkg::KIND_JOINTS)
                        ? (rsp_tdata[2:0] == sfd_pkg::JOINT_LAST_IDX)
                        : (rsp_tdata[2:0] == sfd_pkg::SERVO_LAST_IDX)))
      else $error("run end does not match item index");

   assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("register write port not ready");

endmodule

bind serial_frame_deframer_checksum sfd_checker u_sfd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_ready  (csr_ready)
);

`default_nettype wire
